// ----- sv/mad_pkg.sv -----
// Package for the moving-average threshold detector.
// Fixed register widths, register index codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package mad_pkg;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WLEN_CFG_W = 7;
	localparam int THR_W      = 16;

	localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD     = 2'd1;

	localparam logic [WLEN_CFG_W-1:0] WLEN_RESET = 7'd1;
	localparam logic [THR_W-1:0]      THR_RESET  = 16'd0;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SUM   = 5'b00010,
		ST_START = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_EMIT  = 5'b10000
	} mad_state_t;

endpackage

// ----- sv/mad_ifs.sv -----
// Channel interfaces of the moving-average threshold detector.
// Sample input, event output and register write channel; uses mad_pkg.
`timescale 1ns / 1ps

interface mad_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface mad_out_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int INDEX_WIDTH  = 24
);
	logic                           valid;
	logic                           ready;
	logic        [INDEX_WIDTH-1:0]  event_index;
	logic signed [SAMPLE_WIDTH-1:0] event_value;
	logic signed [SAMPLE_WIDTH-1:0] event_average;

	modport source (output valid, output event_index, output event_value,
		output event_average, input ready);
	modport sink   (input valid, input event_index, input event_value,
		input event_average, output ready);
endinterface

interface mad_cfg_if
	import mad_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mad_div.sv -----
// Bit-serial floored divider: signed window sum by unsigned window length.
// One quotient bit per cycle (restoring), then a sign fix step. No package use.
`timescale 1ns / 1ps

module mad_div #(
	parameter int SUM_W  = 22,
	parameter int WLEN_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [WLEN_W-1:0]       divisor,
	output logic                    done,
	output logic signed [SUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic              run_q;
	logic              fix_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  dq_q;     // dividend shifts out, quotient shifts in
	logic [WLEN_W-1:0] rem_q;
	logic              neg_q;
	logic [WLEN_W:0]   trial;
	logic [WLEN_W:0]   diff;
	logic              qbit;

	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign qbit  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(SUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			dq_q  <= dividend[SUM_W-1] ? -dividend : dividend;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= qbit ? diff[WLEN_W-1:0] : trial[WLEN_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], qbit};
		end else if (fix_q) begin
			// floor for negative sums: -q - (rem != 0) == ~q + (rem == 0)
			quotient <= neg_q ? $signed(~dq_q + SUM_W'(rem_q == '0)) : $signed(dq_q);
		end
	end

	assign done = done_q;

endmodule

// ----- sv/moving_average_threshold_detector_top.sv -----
// Moving-average threshold detector, top level. Uses mad_pkg, mad_ifs, mad_div.
// The window sum is SAMPLE_WIDTH + log2 MAX_WINDOW bits wide. A sample is taken only
// in ST_IDLE, so a new sample waits until the last one has passed the ring walk (one
// memory read a cycle), the bit-serial divider and ST_EMIT. An event waiting in the
// output register does not hold off the next sample; only a further hit waits in
// ST_EMIT until the register is free. Reset: window length 1, threshold 0, block
// empty; ring memory is not cleared, unwritten slots are masked by the count.
`timescale 1ns / 1ps

module moving_average_threshold_detector_top
	import mad_pkg::*;
#(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 16,
	parameter int INDEX_WIDTH  = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	mad_cfg_if.sink   cfg,
	mad_in_if.sink    samples,
	mad_out_if.source events
);

	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int WLEN_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
	localparam int CMP_W  = (INDEX_WIDTH > WLEN_W) ? INDEX_WIDTH : WLEN_W;
	localparam int QC_W   = (SUM_W > THR_W) ? SUM_W : THR_W;

	mad_state_t state_q;

	logic        [WLEN_CFG_W-1:0]   wlen_q;
	logic signed [THR_W-1:0]        thr_q;
	logic        [PTR_W-1:0]        wp_q;
	logic        [INDEX_WIDTH-1:0]  seen_q;
	logic        [WLEN_W-1:0]       w_q;
	logic        [WLEN_W-1:0]       k_q;
	logic        [PTR_W-1:0]        rd_addr_q;
	logic        [INDEX_WIDTH-1:0]  idx_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                           elig_q;
	logic signed [SUM_W-1:0]        acc_q;
	logic signed [SAMPLE_WIDTH-1:0] rd_data_s1;
	logic                           rd_valid_s1;
	logic                           take_s1;
	logic                           out_valid_q;
	logic        [INDEX_WIDTH-1:0]  out_index_q;
	logic signed [SAMPLE_WIDTH-1:0] out_value_q;
	logic signed [SAMPLE_WIDTH-1:0] out_avg_q;

	logic signed [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];

	logic                    in_fire;
	logic                    rd_en;
	logic [31:0]             wl32;
	logic [31:0]             wclamp32;
	logic [WLEN_W-1:0]       w_eff;
	logic                    div_start;
	logic                    div_done;
	logic signed [SUM_W-1:0] div_quot;
	logic signed [QC_W-1:0]  q_ext;
	logic signed [QC_W-1:0]  thr_ext;
	logic                    hit;
	logic                    out_free;

	assign cfg.ready     = 1'b1;
	assign samples.ready = (state_q == ST_IDLE);
	assign in_fire       = samples.valid && samples.ready;

	// window length: zero counts as one, capped at the ring depth
	assign wl32     = 32'(wlen_q);
	assign wclamp32 = (wl32 == 32'd0) ? 32'd1 :
		((wl32 > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : wl32);
	assign w_eff    = wclamp32[WLEN_W-1:0];

	assign rd_en     = (state_q == ST_SUM) && (k_q != w_q);
	assign div_start = (state_q == ST_START);

	assign q_ext    = QC_W'(div_quot);
	assign thr_ext  = QC_W'(thr_q);
	assign hit      = elig_q && (q_ext >= thr_ext);
	assign out_free = !out_valid_q || events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
			thr_q  <= THR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_WINDOW_LENGTH: wlen_q <= cfg.data[WLEN_CFG_W-1:0];
				CFG_THRESHOLD:     thr_q  <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			seen_q      <= '0;
			k_q         <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			// a new event may replace one leaving in the same cycle
			if (state_q == ST_EMIT && hit && out_free)
				out_valid_q <= 1'b1;
			else if (events.valid && events.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						k_q     <= '0;
						state_q <= ST_SUM;
						if (samples.last_sample) begin
							wp_q   <= '0;
							seen_q <= '0;
						end else begin
							wp_q <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
							if (seen_q != '1)
								seen_q <= seen_q + 1'b1;
						end
					end
				end
				ST_SUM: begin
					if (rd_en)
						k_q <= k_q + 1'b1;
					else
						state_q <= ST_START;
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!hit || out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-sample payload and the ring walk
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q  <= samples.sample;
			idx_q     <= seen_q;
			w_q       <= w_eff;
			rd_addr_q <= wp_q;
			elig_q    <= (CMP_W'(seen_q) >= CMP_W'(w_eff - 1'b1));
			acc_q     <= '0;
		end else begin
			if (rd_en) begin
				rd_addr_q <= (rd_addr_q == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_addr_q - 1'b1;
				// slots older than the block's first sample count as zero
				take_s1   <= (CMP_W'(k_q) <= CMP_W'(idx_q));
			end
			if (rd_valid_s1 && take_s1)
				acc_q <= acc_q + SUM_W'(rd_data_s1);
		end
		if (state_q == ST_EMIT && hit && out_free) begin
			out_index_q <= idx_q;
			out_value_q <= sample_q;
			out_avg_q   <= div_quot[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			ring_mem[wp_q] <= samples.sample;
		if (rd_en)
			rd_data_s1 <= ring_mem[rd_addr_q];
	end

	mad_div #(
		.SUM_W  (SUM_W),
		.WLEN_W (WLEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (w_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign events.valid         = out_valid_q;
	assign events.event_index   = out_index_q;
	assign events.event_value   = out_value_q;
	assign events.event_average = out_avg_q;

endmodule
